/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dcplm_pkg.sv */
// Types and constants for the dual channel peak level meter.
// Used by the front, queue, back and top-level modules.
package dcplm_pkg;

  localparam logic [11:0] MIDSCALE       = 12'd2048;
  localparam logic [6:0]  PCT_SCALE      = 7'd100;
  localparam logic [6:0]  HOLD_CAP       = 7'd99;
  localparam logic [11:0] NOISE_FLOOR_RST = 12'd200;
  localparam logic [11:0] FULL_SCALE_RST  = 12'd1800;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Quotient bits of the level divide; percent never exceeds 100.
  localparam int DIV_STEPS = 7;

  localparam logic REG_NOISE_FLOOR = 1'b0;
  localparam logic REG_FULL_SCALE  = 1'b1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        ch;
    logic [11:0] peak;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [11:0] noise_floor;
    logic [11:0] full_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_LOAD
  } back_state_t;

  // floor(p / 10) for p up to 100, by reciprocal 205/2048.
  function automatic logic [3:0] bar_of(logic [6:0] p);
    logic [14:0] t;
    t = 15'(p) * 15'd205;
    return t[14:11];
  endfunction

endpackage

/* sv/dual_channel_peak_level_meter.sv */
// Dual channel peak level meter.
// Input stream s_*: one item per request. s_tuser[0] selects an ADC sample
// (0) or the one-second tick (1); s_tuser[1] is the channel, s_tdata[11:0]
// the sample and s_tlast the last sample of that channel's frame.
// Output stream m_*: m_tuser[0] is 0 for a frame level report (channel in
// m_tuser[1], percent and bar count in m_tdata) and 1 for the packed
// per-second peaks (m_tdata[24:11]).
// cfg_*: index 0 writes noise_floor, index 1 full_scale; write only when idle.
// Samples are taken one per cycle while the queue has room. A frame end or a
// tick queues a request in a four-entry queue. A level request goes through
// the back end in order (setup, x100 multiply, 7 restoring divide steps,
// output load); a tick is loaded from the queue straight to the output.
// The back end takes a new request only from idle, after the last is loaded.
// When the queue is full s_tready drops. A stalled m_tready holds the output
// register and then the back end, and the queue fills behind it.
// Reset (rst, synchronous) clears peaks, holds, queue and output valid, and
// loads noise_floor 200 and full_scale 1800.
module dual_channel_peak_level_meter #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  input  logic        s_tlast,
  input  logic [1:0]  s_tuser,   // [0] func, [1] channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [6:0] level_percent, [10:7] bar_count,
                                 // [24:11] packed_peaks, [31:25] zero
  output logic [1:0]  m_tuser,   // [0] report_kind, [1] level_channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import dcplm_pkg::*;

  cfg_t      cfg;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t qstat;
  logic      push;
  logic      pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_floor <= NOISE_FLOOR_RST;
      cfg.full_scale  <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOISE_FLOOR: cfg.noise_floor <= cfg_data;
        REG_FULL_SCALE:  cfg.full_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  dcplm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser[0]),
    .ch        (s_tuser[1]),
    .sample    (s_tdata[11:0]),
    .frame_end (s_tlast),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dcplm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  dcplm_back #(.CHANNELS(CHANNELS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* sv/dcplm_fifo.sv */
// Short command queue between the front and the back.
// Depends on dcplm_pkg for cmd_t, q_status_t and QDEPTH.
module dcplm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dcplm_pkg::cmd_t     push_cmd,
  input  logic                pop,
  output dcplm_pkg::cmd_t     head,
  output dcplm_pkg::q_status_t status
);
  import dcplm_pkg::*;

  cmd_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign status.empty = (count == '0);
  assign status.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* sv/dcplm_front.sv */
// Front end: takes samples and ticks, tracks per-channel frame peaks,
// queues a request at each frame end and each tick. Depends on dcplm_pkg.
module dcplm_front #(
  parameter int CHANNELS = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic            func,
  input  logic            ch,
  input  logic [11:0]     sample,
  input  logic            frame_end,
  output logic            push,
  output dcplm_pkg::cmd_t push_cmd
);
  import dcplm_pkg::*;

  logic [11:0] frame_peak [CHANNELS];
  logic [11:0] cur_peak;
  logic [11:0] dev;
  logic [11:0] new_peak;
  logic        ch_ok;
  logic        accept;
  logic        is_tick;

  assign accept  = in_valid && in_ready;
  assign is_tick = (func == FUNC_TICK);

  // |sample - 2048|, at most 2048
  assign dev = sample[11] ? {1'b0, sample[10:0]} : (MIDSCALE - sample);

  always_comb begin
    cur_peak = '0;
    ch_ok    = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (ch == 1'(i)) begin
        cur_peak = frame_peak[i];
        ch_ok    = 1'b1;
      end
    end
  end

  assign new_peak = (dev > cur_peak) ? dev : cur_peak;

  assign push          = accept && (is_tick || (ch_ok && frame_end));
  assign push_cmd.kind = is_tick ? KIND_TICK : KIND_LEVEL;
  assign push_cmd.ch   = ch;
  assign push_cmd.peak = new_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) frame_peak[i] <= '0;
    end else if (accept && !is_tick) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (ch == 1'(i)) frame_peak[i] <= frame_end ? 12'd0 : new_peak;
      end
    end
  end

endmodule

/* sv/dcplm_back.sv */
// Back end: turns queued requests into reports. Level requests go through
// floor, clamp, x100 and a 7-step divide; ticks pack the holds. Uses dcplm_pkg.
module dcplm_back #(
  parameter int CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dcplm_pkg::cfg_t      cfg,
  input  dcplm_pkg::cmd_t      head,
  input  dcplm_pkg::q_status_t qstat,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic [1:0]           m_tuser
);
  import dcplm_pkg::*;

  back_state_t state, state_next;

  logic [6:0]  second_hold [CHANNELS];
  logic [11:0] lvl;
  logic        cur_ch;
  logic [11:0] rem;
  logic [6:0]  num_lo;
  logic [6:0]  quot;
  logic [2:0]  step;

  logic        out_free;
  logic        ld_tick;
  logic        ld_level;
  logic        take_level;
  logic        do_mul;
  logic        do_div;

  logic [11:0] lvl_floor;
  logic [11:0] lvl_clamp;
  logic [18:0] prod;
  logic [12:0] shifted;
  logic        q_bit;
  logic [12:0] rem_sub;
  logic [6:0]  pct;
  logic [13:0] packed_val;

  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!qstat.empty && head.kind == KIND_LEVEL) state_next = B_MUL;
      B_MUL:  state_next = B_DIV;
      B_DIV:  if (step == 3'(DIV_STEPS - 1)) state_next = B_LOAD;
      B_LOAD: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ld_tick    = 1'b0;
    ld_level   = 1'b0;
    take_level = 1'b0;
    do_mul     = 1'b0;
    do_div     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          if (head.kind == KIND_TICK) ld_tick = out_free;
          else                        take_level = 1'b1;
        end
      end
      B_MUL:  do_mul = 1'b1;
      B_DIV:  do_div = 1'b1;
      B_LOAD: ld_level = out_free;
      default: ;
    endcase
  end

  assign pop = ld_tick || take_level;

  assign lvl_floor = (head.peak < cfg.noise_floor) ? 12'd0 : (head.peak - cfg.noise_floor);
  assign lvl_clamp = (lvl_floor > cfg.full_scale) ? cfg.full_scale : lvl_floor;

  assign prod    = 19'(lvl) * 19'(PCT_SCALE);
  assign shifted = {rem, num_lo[6]};
  assign q_bit   = (shifted >= {1'b0, cfg.full_scale});
  assign rem_sub = q_bit ? (shifted - {1'b0, cfg.full_scale}) : shifted;

  assign pct = (cfg.full_scale == 12'd0) ? 7'd0 : quot;

  always_comb begin
    logic [6:0] h;
    packed_val = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      h = (second_hold[i] > HOLD_CAP) ? HOLD_CAP : second_hold[i];
      packed_val = 14'(packed_val * 14'd100 + 14'(h));
    end
  end

  always_ff @(posedge clk) begin
    if (take_level) begin
      lvl    <= lvl_clamp;
      cur_ch <= head.ch;
    end
    if (do_mul) begin
      rem    <= 12'(prod[18:7]);
      num_lo <= prod[6:0];
      quot   <= '0;
    end
    if (do_div) begin
      rem    <= rem_sub[11:0];
      num_lo <= {num_lo[5:0], 1'b0};
      quot   <= {quot[5:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
      for (int i = 0; i < CHANNELS; i++) second_hold[i] <= '0;
    end else begin
      state <= state_next;
      if (do_mul)      step <= '0;
      else if (do_div) step <= step + 1'b1;
      if (ld_tick) begin
        for (int i = 0; i < CHANNELS; i++) second_hold[i] <= '0;
      end else if (ld_level) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (cur_ch == 1'(i) && pct > second_hold[i]) second_hold[i] <= pct;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld_tick || ld_level) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_tick) begin
      m_tdata <= {7'd0, packed_val, 4'd0, 7'd0};
      m_tuser <= {1'b0, KIND_TICK};
    end else if (ld_level) begin
      m_tdata <= {7'd0, 14'd0, bar_of(pct), pct};
      m_tuser <= {cur_ch, KIND_LEVEL};
    end
  end

endmodule

/* sv/dcplm_checker.sv */
// Port-level checks for the peak level meter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dcplm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  property p_stall_holds;
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
  endproperty

  // bar count is the percent divided by ten, rounded down
  property p_level_fields;
    m_tvalid && !m_tuser[0] |->
      m_tdata[6:0] <= 7'd100 && m_tdata[24:11] == 14'd0 &&
      8'(m_tdata[10:7]) * 8'd10 <= 8'(m_tdata[6:0]) &&
      8'(m_tdata[6:0]) < 8'(m_tdata[10:7]) * 8'd10 + 8'd10;
  endproperty

  property p_tick_fields;
    m_tvalid && m_tuser[0] |->
      m_tdata[10:0] == 11'd0 && !m_tuser[1] && m_tdata[24:11] <= 14'd9999;
  endproperty

  `ASSERT_ALWAYS(a_reset_clears_valid, rst |=> !m_tvalid, "output valid after reset")

  `ASSERT_CLK(a_stall_holds, p_stall_holds, "stalled report changed")

  `ASSERT_CLK(a_level_fields, p_level_fields, "bad level report")

  `ASSERT_CLK(a_tick_fields, p_tick_fields, "bad packed report")

endmodule

bind dual_channel_peak_level_meter dcplm_checker u_dcplm_checker (.*);
